/* src/vspa_pkg.sv */
package vspa_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned VER_W  = 32;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOOKUP  = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FREE    = 3'd3,
    ST_VERSION = 3'd4
  } status_e;

  // Version held by a slot that has never been written.
  localparam logic [VER_W-1:0] VER_RESET = '1;

  // Flag updates from the resolve step.
  typedef struct packed {
    logic reserve;    // mark slot reserved and its version written
    logic unreserve;  // mark slot free
  } flag_upd_t;

  // Flags seen at the looked-up slot plus the free-slot search result.
  typedef struct packed {
    logic any_free;
    logic reserved;
    logic written;
  } flag_look_t;

endpackage

/* src/vspa_ram.sv */
module vspa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/vspa_slot_flags.sv */
module vspa_slot_flags #(
  parameter int unsigned NUM_SLOTS = 64,
  parameter int unsigned AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vspa_pkg::flag_upd_t upd_i,
  input  logic [AW-1:0]       upd_idx_i,
  input  logic [AW-1:0]       look_idx_i,
  output vspa_pkg::flag_look_t look_o,
  output logic [AW-1:0]       free_idx_o
);
  import vspa_pkg::*;

  logic [NUM_SLOTS-1:0] reserved_q, reserved_d;
  logic [NUM_SLOTS-1:0] written_q, written_d;
  logic                 any_free;
  logic [AW-1:0]        free_idx;

  always_comb begin
    reserved_d = reserved_q;
    written_d  = written_q;
    if (upd_i.reserve) begin
      reserved_d[upd_idx_i] = 1'b1;
      written_d[upd_idx_i]  = 1'b1;
    end
    if (upd_i.unreserve) begin
      reserved_d[upd_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
      written_q  <= '0;
    end else begin
      reserved_q <= reserved_d;
      written_q  <= written_d;
    end
  end

  // lowest free slot wins
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!reserved_q[i]) begin
        any_free = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign look_o.any_free = any_free;
  assign look_o.reserved = reserved_q[look_idx_i];
  assign look_o.written  = written_q[look_idx_i];
  assign free_idx_o      = free_idx;

endmodule

/* src/versioned_slot_pool_allocator_unit.sv */
// Versioned slot pool allocator: keeps NUM_SLOTS slots (1..255), each with
// a reserved flag and a 32-bit version, and serves one request item at a
// time. Allocate grants the lowest free slot and bumps its version (the
// first grant of a slot yields version 0); release checks a handle and
// frees the slot; lookup only checks the handle (kind 3 acts as lookup).
// Checks run in order: index in range, slot reserved, version equal; the
// first failure sets status and the request is echoed unchanged.
// No new item is accepted until the current one is resolved. Accepting an
// item issues the version memory read; the resolve state then resolves the
// item, writes the memory and loads the result register. The version
// memory read is registered, hence the separate resolve state. A stalled
// result holds the resolve step. Reserved and written flags sit in
// flip-flops cleared by reset, so no clearing pass is needed: a
// never-written slot reads as version all ones.
module versioned_slot_pool_allocator_unit #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [vspa_pkg::KIND_W-1:0]  kind_i,
  input  logic [vspa_pkg::IDX_W-1:0]   slot_index_i,
  input  logic [vspa_pkg::VER_W-1:0]   slot_version_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vspa_pkg::STAT_W-1:0]  status_o,
  output logic [vspa_pkg::IDX_W-1:0]   granted_index_o,
  output logic [vspa_pkg::VER_W-1:0]   granted_version_o
);
  import vspa_pkg::*;

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] NumSlotsIdx = IDX_W'(NUM_SLOTS);

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_e;

  state_e state_q;

  // request held across the memory read
  logic [KIND_W-1:0] kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VER_W-1:0]  ver_q;
  logic              full_q;
  logic [AW-1:0]     addr_q;

  // result register
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [IDX_W-1:0]  gidx_q;
  logic [VER_W-1:0]  gver_q;

  logic              accept;
  logic              done;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     free_idx;
  logic [VER_W-1:0]  ram_rdata;
  logic [VER_W-1:0]  stored_ver;
  logic [VER_W-1:0]  bumped_ver;
  flag_look_t        look;
  flag_upd_t         upd;
  logic              ram_we;
  status_e           res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [VER_W-1:0]  res_ver;
  logic [AW-1:0]     look_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  // resolve only when the result register can take the outcome
  assign done       = (state_q == S_RESOLVE) && (!out_valid_q || !out_stall_i);

  // allocate reads the slot the encoder picked, others read the handle's slot
  assign rd_addr  = (kind_i == KIND_ALLOC) ? free_idx : slot_index_i[AW-1:0];
  assign look_idx = (state_q == S_IDLE) ? rd_addr : addr_q;

  vspa_slot_flags #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_flags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .upd_idx_i  (addr_q),
    .look_idx_i (look_idx),
    .look_o     (look),
    .free_idx_o (free_idx)
  );

  vspa_ram #(
    .WIDTH (VER_W),
    .DEPTH (NUM_SLOTS),
    .AW    (AW)
  ) u_ver_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (bumped_ver),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // never-written slot holds the reset version
  assign stored_ver = look.written ? ram_rdata : VER_RESET;
  assign bumped_ver = stored_ver + VER_W'(1);

  always_comb begin
    res_status    = ST_OK;
    res_idx       = idx_q;
    res_ver       = ver_q;
    upd.reserve   = 1'b0;
    upd.unreserve = 1'b0;
    ram_we        = 1'b0;
    if (kind_q == KIND_ALLOC) begin
      if (full_q) begin
        res_status = ST_FULL;
      end else begin
        res_idx     = IDX_W'(addr_q);
        res_ver     = bumped_ver;
        upd.reserve = done;
        ram_we      = done;
      end
    end else begin
      priority if (idx_q >= NumSlotsIdx) begin
        res_status = ST_RANGE;
      end else if (!look.reserved) begin
        res_status = ST_FREE;
      end else if (stored_ver != ver_q) begin
        res_status = ST_VERSION;
      end else begin
        res_status    = ST_OK;
        upd.unreserve = done && (kind_q == KIND_RELEASE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      idx_q       <= '0;
      ver_q       <= '0;
      full_q      <= 1'b0;
      addr_q      <= '0;
      status_q    <= '0;
      gidx_q      <= '0;
      gver_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q  <= kind_i;
            idx_q   <= slot_index_i;
            ver_q   <= slot_version_i;
            full_q  <= !look.any_free;
            addr_q  <= rd_addr;
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (done) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (done) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
        gidx_q      <= res_idx;
        gver_q      <= res_ver;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_index_o   = gidx_q;
  assign granted_version_o = gver_q;

endmodule

/* src/vspa_checker.sv */
module vspa_checker #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [vspa_pkg::STAT_W-1:0]  status_o,
  input logic [vspa_pkg::IDX_W-1:0]   granted_index_o,
  input logic [vspa_pkg::VER_W-1:0]   granted_version_o
);
  import vspa_pkg::*;

  localparam logic [IDX_W-1:0] NumSlotsIdx = IDX_W'(NUM_SLOTS);

  // one item in flight: an accepted item blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_VERSION))
    else $error("status code out of range");

  // range failure echoes the out-of-range index
  a_range_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE)) |-> (granted_index_o >= NumSlotsIdx))
    else $error("range status with in-range index");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(granted_index_o)
       && $stable(granted_version_o)))
    else $error("stalled result changed");

endmodule

bind versioned_slot_pool_allocator_unit vspa_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_vspa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .granted_index_o   (granted_index_o),
  .granted_version_o (granted_version_o)
);
